// ----- rtl/core/cicm_pkg.sv -----
// Shared types, opcode and truth codes, and the mask helper for the CIDR compare/mask unit.
// No dependencies; imported by every module under rtl/core.
package cicm_pkg;

   // Opcodes
   localparam logic [4:0] CMD_EQ       = 5'd0;
   localparam logic [4:0] CMD_NEQ      = 5'd1;
   localparam logic [4:0] CMD_LT       = 5'd2;
   localparam logic [4:0] CMD_GT       = 5'd3;
   localparam logic [4:0] CMD_LE       = 5'd4;
   localparam logic [4:0] CMD_GE       = 5'd5;
   localparam logic [4:0] CMD_CW       = 5'd6;
   localparam logic [4:0] CMD_CWE      = 5'd7;
   localparam logic [4:0] CMD_CS       = 5'd8;
   localparam logic [4:0] CMD_CSE      = 5'd9;
   localparam logic [4:0] CMD_ISNIL    = 5'd10;
   localparam logic [4:0] CMD_BCAST    = 5'd11;
   localparam logic [4:0] CMD_NETMASK  = 5'd12;
   localparam logic [4:0] CMD_HOSTMASK = 5'd13;
   localparam logic [4:0] CMD_NETWORK  = 5'd14;
   localparam logic [4:0] CMD_MASKLEN  = 5'd15;
   localparam logic [4:0] CMD_SETMASK  = 5'd16;

   // Three-valued comparison answer
   localparam logic [1:0] TRUTH_FALSE = 2'd0;
   localparam logic [1:0] TRUTH_TRUE  = 2'd1;
   localparam logic [1:0] TRUTH_NIL   = 2'd2;

   localparam logic [5:0] FULL_PREFIX = 6'd32;

   // Stage 1 -> stage 2: operands plus masks and the wide address compares
   typedef struct packed {
      logic [4:0]  cmd;
      logic [31:0] a_addr;
      logic [31:0] b_addr;
      logic [5:0]  a_prefix;
      logic [5:0]  b_prefix;
      logic        a_nil;
      logic        b_nil;
      logic [31:0] mask_a;
      logic [31:0] mask_b;
      logic        addr_eq;
      logic        addr_lt;
      logic        np_bad;
      logic [5:0]  np_val;
   } s1_type;

   // Stage 2 -> stage 3: relation flags and candidate function results
   typedef struct packed {
      logic [4:0]  cmd;
      logic        a_nil;
      logic        any_nil;
      logic        eq;
      logic        lt;
      logic        gt;
      logic        cw;
      logic        cs;
      logic [31:0] a_addr;
      logic [5:0]  a_prefix;
      logic [31:0] mask_a;
      logic [31:0] bcast_addr;
      logic [31:0] net_addr;
      logic        np_bad;
      logic [5:0]  np_val;
   } s2_type;

   // Network mask for a prefix length; lengths above 32 saturate
   function automatic logic [31:0] net_mask(input logic [5:0] prefix);
      logic [5:0] shift;
      shift = FULL_PREFIX - prefix;
      if (prefix == 6'd0) begin
         return 32'h0000_0000;
      end else if (prefix >= FULL_PREFIX) begin
         return 32'hFFFF_FFFF;
      end
      return 32'hFFFF_FFFF << shift;
   endfunction

endpackage

// ----- rtl/core/cicm_prep.sv -----
// Stage 1 of the CIDR unit: mask generation, wide address compares, length range check.
// Depends on cicm_pkg.
module cicm_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 load,
   input  logic [4:0]           cmd,
   input  logic [31:0]          a_addr,
   input  logic [5:0]           a_prefix,
   input  logic                 a_is_nil,
   input  logic [31:0]          b_addr,
   input  logic [5:0]           b_prefix,
   input  logic                 b_is_nil,
   input  logic signed [6:0]    new_prefix,
   output logic                 out_valid,
   output cicm_pkg::s1_type     out_data
);
   import cicm_pkg::*;

   logic   valid_ff;
   s1_type data_ff;
   s1_type data_in;

   // Operand prep
   always_comb begin
      data_in.cmd      = cmd;
      data_in.a_addr   = a_addr;
      data_in.b_addr   = b_addr;
      data_in.a_prefix = a_prefix;
      data_in.b_prefix = b_prefix;
      data_in.a_nil    = a_is_nil;
      data_in.b_nil    = b_is_nil;
      data_in.mask_a   = net_mask(a_prefix);
      data_in.mask_b   = net_mask(b_prefix);
      data_in.addr_eq  = (a_addr == b_addr);
      data_in.addr_lt  = (a_addr < b_addr);
      // negative or above 32 is rejected
      data_in.np_bad   = new_prefix[6] || (new_prefix[5:0] > FULL_PREFIX);
      data_in.np_val   = new_prefix[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/core/cicm_relate.sv -----
// Stage 2 of the CIDR unit: ordering and containment flags, masked address results.
// Depends on cicm_pkg.
module cicm_relate (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 load,
   input  cicm_pkg::s1_type     in_data,
   output logic                 out_valid,
   output cicm_pkg::s2_type     out_data
);
   import cicm_pkg::*;

   logic        valid_ff;
   s2_type      data_ff;
   s2_type      data_in;
   logic [31:0] diff;
   logic        pre_eq;
   logic        pre_lt;
   logic        pre_gt;

   // Relations between the two operands
   always_comb begin
      diff   = in_data.a_addr ^ in_data.b_addr;
      pre_eq = (in_data.a_prefix == in_data.b_prefix);
      pre_lt = (in_data.a_prefix < in_data.b_prefix);
      pre_gt = (in_data.a_prefix > in_data.b_prefix);

      data_in.cmd        = in_data.cmd;
      data_in.a_nil      = in_data.a_nil;
      data_in.any_nil    = in_data.a_nil || in_data.b_nil;
      data_in.eq         = in_data.addr_eq && pre_eq;
      // address first, then prefix length
      data_in.lt         = in_data.addr_eq ? pre_lt : in_data.addr_lt;
      data_in.gt         = in_data.addr_eq ? pre_gt : !in_data.addr_lt;
      // strictly longer prefix whose leading bits match the shorter one
      data_in.cw         = pre_gt && ((diff & in_data.mask_b) == 32'h0000_0000);
      data_in.cs         = pre_lt && ((diff & in_data.mask_a) == 32'h0000_0000);
      data_in.a_addr     = in_data.a_addr;
      data_in.a_prefix   = in_data.a_prefix;
      data_in.mask_a     = in_data.mask_a;
      data_in.bcast_addr = in_data.a_addr | ~in_data.mask_a;
      data_in.net_addr   = in_data.a_addr & in_data.mask_a;
      data_in.np_bad     = in_data.np_bad;
      data_in.np_val     = in_data.np_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/core/cicm_select.sv -----
// Stage 3 of the CIDR unit: opcode select, nil handling and the response register.
// Depends on cicm_pkg.
module cicm_select (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 load,
   input  cicm_pkg::s2_type     in_data,
   output logic                 out_valid,
   output logic [1:0]           truth,
   output logic [31:0]          out_addr,
   output logic [5:0]           out_prefix,
   output logic                 out_is_nil,
   output logic                 bad_length
);
   import cicm_pkg::*;

   logic        valid_ff;
   logic [1:0]  truth_ff;
   logic [31:0] addr_ff;
   logic [5:0]  prefix_ff;
   logic        nil_ff;
   logic        bad_ff;
   logic [1:0]  truth_in;
   logic [31:0] addr_in;
   logic [5:0]  prefix_in;
   logic        nil_in;
   logic        bad_in;
   logic        rel;

   // Comparison outcome for the relational opcodes
   always_comb begin
      case (in_data.cmd)
         CMD_EQ:  rel = in_data.eq;
         CMD_NEQ: rel = !in_data.eq;
         CMD_LT:  rel = in_data.lt;
         CMD_GT:  rel = in_data.gt;
         CMD_LE:  rel = in_data.lt || in_data.eq;
         CMD_GE:  rel = in_data.gt || in_data.eq;
         CMD_CW:  rel = in_data.cw;
         CMD_CWE: rel = in_data.cw || in_data.eq;
         CMD_CS:  rel = in_data.cs;
         CMD_CSE: rel = in_data.cs || in_data.eq;
         default: rel = 1'b0;
      endcase
   end

   // Result fields; anything an opcode does not define stays zero
   always_comb begin
      truth_in  = TRUTH_FALSE;
      addr_in   = 32'h0000_0000;
      prefix_in = 6'd0;
      nil_in    = 1'b0;
      bad_in    = 1'b0;
      if (in_data.cmd inside {[CMD_EQ:CMD_CSE]}) begin
         if (in_data.any_nil) begin
            truth_in = TRUTH_NIL;
         end else begin
            truth_in = rel ? TRUTH_TRUE : TRUTH_FALSE;
         end
      end else if (in_data.cmd == CMD_ISNIL) begin
         truth_in = in_data.a_nil ? TRUTH_TRUE : TRUTH_FALSE;
      end else if (in_data.cmd == CMD_SETMASK) begin
         // range check wins over a nil operand
         if (in_data.np_bad) begin
            bad_in = 1'b1;
         end else if (in_data.a_nil) begin
            nil_in = 1'b1;
         end else begin
            addr_in   = in_data.a_addr;
            prefix_in = in_data.np_val;
         end
      end else if (in_data.cmd inside {[CMD_BCAST:CMD_MASKLEN]}) begin
         if (in_data.a_nil) begin
            nil_in = 1'b1;
         end else begin
            case (in_data.cmd)
               CMD_BCAST: begin
                  addr_in   = in_data.bcast_addr;
                  prefix_in = in_data.a_prefix;
               end
               CMD_NETMASK: begin
                  addr_in   = in_data.mask_a;
                  prefix_in = FULL_PREFIX;
               end
               CMD_HOSTMASK: begin
                  addr_in   = ~in_data.mask_a;
                  prefix_in = FULL_PREFIX;
               end
               CMD_NETWORK: begin
                  addr_in   = in_data.net_addr;
                  prefix_in = in_data.a_prefix;
               end
               default: begin
                  prefix_in = in_data.a_prefix;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         truth_ff  <= truth_in;
         addr_ff   <= addr_in;
         prefix_ff <= prefix_in;
         nil_ff    <= nil_in;
         bad_ff    <= bad_in;
      end
   end

   assign out_valid  = valid_ff;
   assign truth      = truth_ff;
   assign out_addr   = addr_ff;
   assign out_prefix = prefix_ff;
   assign out_is_nil = nil_ff;
   assign bad_length = bad_ff;

endmodule

// ----- rtl/core/ipv4_cidr_compare_and_mask_alu_unit.sv -----
// IPv4 CIDR compare-and-mask unit: a request carries an opcode, two address/prefix operands
// with nil flags and a requested prefix length; exactly one response comes back for each
// request, in order. The unit takes one request per clock while req_stall is low. A request passes
// through three register stages (mask/compare prep, relation and masked address, opcode select
// into the response register). Each stage holds its request while the next one is full, so a
// stall on rsp_stall backs up through req_stall without dropping or repeating anything, and a new
// request is taken whenever the first stage is free or advancing. No configuration, no state
// between requests.
// Depends on cicm_pkg, cicm_prep, cicm_relate, cicm_select.
module ipv4_cidr_compare_and_mask_alu_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [4:0]           req_cmd,
   input  logic [31:0]          req_a_addr,
   input  logic [5:0]           req_a_prefix,
   input  logic                 req_a_is_nil,
   input  logic [31:0]          req_b_addr,
   input  logic [5:0]           req_b_prefix,
   input  logic                 req_b_is_nil,
   input  logic signed [6:0]    req_new_prefix,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_truth,
   output logic [31:0]          rsp_out_addr,
   output logic [5:0]           rsp_out_prefix,
   output logic                 rsp_out_is_nil,
   output logic                 rsp_bad_length
);
   import cicm_pkg::*;

   logic   s1_valid;
   logic   s2_valid;
   logic   s1_load;
   logic   s2_load;
   logic   s3_load;
   s1_type s1_data;
   s2_type s2_data;

   // Stage advance: a stage loads when it is empty or its contents move on
   assign s3_load   = !rsp_valid || !rsp_stall;
   assign s2_load   = !s2_valid || s3_load;
   assign s1_load   = !s1_valid || s2_load;
   assign req_stall = !s1_load;

   cicm_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .load       (s1_load),
      .cmd        (req_cmd),
      .a_addr     (req_a_addr),
      .a_prefix   (req_a_prefix),
      .a_is_nil   (req_a_is_nil),
      .b_addr     (req_b_addr),
      .b_prefix   (req_b_prefix),
      .b_is_nil   (req_b_is_nil),
      .new_prefix (req_new_prefix),
      .out_valid  (s1_valid),
      .out_data   (s1_data)
   );

   cicm_relate u_relate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .load      (s2_load),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   cicm_select u_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .load       (s3_load),
      .in_data    (s2_data),
      .out_valid  (rsp_valid),
      .truth      (rsp_truth),
      .out_addr   (rsp_out_addr),
      .out_prefix (rsp_out_prefix),
      .out_is_nil (rsp_out_is_nil),
      .bad_length (rsp_bad_length)
   );

endmodule

// ----- rtl/core/cicm_checker.sv -----
// Port-level checks for the CIDR compare/mask unit, attached to the top level by bind.
// Depends on cicm_pkg and ipv4_cidr_compare_and_mask_alu_unit.
module cicm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_truth,
   input  logic [31:0] rsp_out_addr,
   input  logic [5:0]  rsp_out_prefix,
   input  logic        rsp_out_is_nil,
   input  logic        rsp_bad_length
);
   import cicm_pkg::*;

   // A stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_truth) && $stable(rsp_out_addr)
         && $stable(rsp_out_prefix) && $stable(rsp_out_is_nil) && $stable(rsp_bad_length))
      else $error("response payload changed while stalled");

   // A comparison answer carries no function result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truth != TRUTH_FALSE |-> rsp_truth != 2'd3
         && rsp_out_addr == 32'h0000_0000 && rsp_out_prefix == 6'd0
         && !rsp_out_is_nil && !rsp_bad_length)
      else $error("truth set together with function fields");

   // A rejected length clears every other field
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_length |-> rsp_out_addr == 32'h0000_0000
         && rsp_out_prefix == 6'd0 && !rsp_out_is_nil && rsp_truth == TRUTH_FALSE)
      else $error("bad length with nonzero result fields");

   // A nil function result has zero address and length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_is_nil |-> rsp_out_addr == 32'h0000_0000
         && rsp_out_prefix == 6'd0)
      else $error("nil result with nonzero address or length");

endmodule

bind ipv4_cidr_compare_and_mask_alu_unit cicm_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_truth      (rsp_truth),
   .rsp_out_addr   (rsp_out_addr),
   .rsp_out_prefix (rsp_out_prefix),
   .rsp_out_is_nil (rsp_out_is_nil),
   .rsp_bad_length (rsp_bad_length)
);

// ----- tb/tb.sv -----
// Testbench for ipv4_cidr_compare_and_mask_alu_unit: directed table, then random requests,
// each response checked in order against its table entry or a local compare/mask predictor.
// Depends on cicm_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
   import cicm_pkg::*;

   // Opcodes above CMD_SETMASK are unused; the top one is used by name in the table
   localparam logic [4:0] CMD_UNUSED_TOP = 5'd31;
   localparam int unsigned RAND_REQS     = 1750;
   localparam int unsigned IDLE_PCT      = 29;

   typedef struct packed {
      logic [4:0]        cmd;
      logic [31:0]       a_addr;
      logic [5:0]        a_prefix;
      logic              a_nil;
      logic [31:0]       b_addr;
      logic [5:0]        b_prefix;
      logic              b_nil;
      logic [6:0]        new_prefix;
   } cidr_req_type;

   typedef struct packed {
      logic [1:0]        truth;
      logic [31:0]       addr;
      logic [5:0]        prefix;
      logic              nil;
      logic              bad;
   } cidr_rsp_type;

   typedef struct {
      cidr_req_type      stim;
      bit                typed;
      cidr_rsp_type      want;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [4:0]        req_cmd = '0;
   logic [31:0]       req_a_addr = '0;
   logic [5:0]        req_a_prefix = '0;
   logic              req_a_is_nil = 1'b0;
   logic [31:0]       req_b_addr = '0;
   logic [5:0]        req_b_prefix = '0;
   logic              req_b_is_nil = 1'b0;
   logic signed [6:0] req_new_prefix = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_truth;
   logic [31:0]       rsp_out_addr;
   logic [5:0]        rsp_out_prefix;
   logic              rsp_out_is_nil;
   logic              rsp_bad_length;

   cidr_rsp_type      pending_answers[$];
   plan_row_type      directed_plan[$];
   int unsigned       mismatch_cnt = 0;

   ipv4_cidr_compare_and_mask_alu_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_a_addr     (req_a_addr),
      .req_a_prefix   (req_a_prefix),
      .req_a_is_nil   (req_a_is_nil),
      .req_b_addr     (req_b_addr),
      .req_b_prefix   (req_b_prefix),
      .req_b_is_nil   (req_b_is_nil),
      .req_new_prefix (req_new_prefix),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_truth      (rsp_truth),
      .rsp_out_addr   (rsp_out_addr),
      .rsp_out_prefix (rsp_out_prefix),
      .rsp_out_is_nil (rsp_out_is_nil),
      .rsp_bad_length (rsp_bad_length)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // leading-ones mask; lengths of 32 and up give all ones
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      if (len >= 6'd32) return 32'hFFFF_FFFF;
      return ~(32'hFFFF_FFFF >> len);
   endfunction

   // order on address, then on raw prefix length
   function automatic logic ord_less(input logic [31:0] x, input logic [5:0] xp,
                                     input logic [31:0] y, input logic [5:0] yp);
      if (x != y) return x < y;
      return xp < yp;
   endfunction

   // x/xp strictly nested in y/yp
   function automatic logic nested_in(input logic [31:0] x, input logic [5:0] xp,
                                      input logic [31:0] y, input logic [5:0] yp);
      if (xp <= yp) return 1'b0;
      return ((x ^ y) & prefix_mask(yp)) == 32'd0;
   endfunction

   function automatic cidr_rsp_type predict_answer(input cidr_req_type r);
      cidr_rsp_type o;
      logic      same;
      logic      hit;
      logic [31:0] m;
      o    = '0;
      hit  = 1'b0;
      same = (r.a_addr == r.b_addr) && (r.a_prefix == r.b_prefix);
      m    = prefix_mask(r.a_prefix);
      if (r.cmd <= CMD_CSE) begin
         if (r.a_nil || r.b_nil) begin
            o.truth = TRUTH_NIL;
         end else begin
            case (r.cmd)
               CMD_EQ:  hit = same;
               CMD_NEQ: hit = !same;
               CMD_LT:  hit = ord_less(r.a_addr, r.a_prefix, r.b_addr, r.b_prefix);
               CMD_GT:  hit = ord_less(r.b_addr, r.b_prefix, r.a_addr, r.a_prefix);
               CMD_LE:  hit = ord_less(r.a_addr, r.a_prefix, r.b_addr, r.b_prefix) || same;
               CMD_GE:  hit = ord_less(r.b_addr, r.b_prefix, r.a_addr, r.a_prefix) || same;
               CMD_CW:  hit = nested_in(r.a_addr, r.a_prefix, r.b_addr, r.b_prefix);
               CMD_CWE: hit = nested_in(r.a_addr, r.a_prefix, r.b_addr, r.b_prefix) || same;
               CMD_CS:  hit = nested_in(r.b_addr, r.b_prefix, r.a_addr, r.a_prefix);
               default: hit = nested_in(r.b_addr, r.b_prefix, r.a_addr, r.a_prefix) || same;
            endcase
            o.truth = hit ? TRUTH_TRUE : TRUTH_FALSE;
         end
      end else if (r.cmd == CMD_ISNIL) begin
         o.truth = r.a_nil ? TRUTH_TRUE : TRUTH_FALSE;
      end else if (r.cmd == CMD_SETMASK) begin
         // range check wins over a nil operand
         if (r.new_prefix[6] || r.new_prefix[5:0] > 6'd32) begin
            o.bad = 1'b1;
         end else if (r.a_nil) begin
            o.nil = 1'b1;
         end else begin
            o.addr   = r.a_addr;
            o.prefix = r.new_prefix[5:0];
         end
      end else if (r.cmd <= CMD_MASKLEN) begin
         if (r.a_nil) begin
            o.nil = 1'b1;
         end else begin
            case (r.cmd)
               CMD_BCAST: begin
                  o.addr   = r.a_addr | ~m;
                  o.prefix = r.a_prefix;
               end
               CMD_NETMASK: begin
                  o.addr   = m;
                  o.prefix = 6'd32;
               end
               CMD_HOSTMASK: begin
                  o.addr   = ~m;
                  o.prefix = 6'd32;
               end
               CMD_NETWORK: begin
                  o.addr   = r.a_addr & m;
                  o.prefix = r.a_prefix;
               end
               default: o.prefix = r.a_prefix;
            endcase
         end
      end
      return o;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic cidr_req_type mk_req(input logic [4:0] cmd,
                                           input logic [31:0] a, input logic [5:0] ap,
                                           input logic an,
                                           input logic [31:0] b, input logic [5:0] bp,
                                           input logic bn, input logic [6:0] np);
      cidr_req_type r;
      r = '{cmd, a, ap, an, b, bp, bn, np};
      return r;
   endfunction

   task automatic add_row(input cidr_req_type s, input bit typed, input cidr_rsp_type w);
      plan_row_type row;
      row.stim  = s;
      row.typed = typed;
      row.want  = w;
      directed_plan.push_back(row);
   endtask

   // mostly legal lengths, sometimes the oversized ones
   function automatic logic [5:0] rand_prefix();
      if ($urandom_range(0, 6) == 0) return 6'($urandom_range(33, 63));
      return 6'($urandom_range(0, 32));
   endfunction

   function automatic cidr_req_type rand_req();
      cidr_req_type r;
      logic [31:0]  keep;
      if ($urandom_range(0, 19) == 0)
         r.cmd = 5'($urandom_range(CMD_SETMASK + 1, CMD_UNUSED_TOP));
      else
         r.cmd = 5'($urandom_range(CMD_EQ, CMD_SETMASK));
      r.a_addr   = $urandom;
      r.a_prefix = rand_prefix();
      keep       = prefix_mask(6'($urandom_range(0, 32)));
      // b related to a most of the time so containment and equality come up
      case ($urandom_range(0, 3))
         0: begin
            r.b_addr   = $urandom;
            r.b_prefix = rand_prefix();
         end
         1: begin
            r.b_addr   = (r.a_addr & keep) | ($urandom & ~keep);
            r.b_prefix = rand_prefix();
         end
         2: begin
            r.b_addr   = r.a_addr;
            r.b_prefix = rand_prefix();
         end
         default: begin
            r.b_addr   = r.a_addr;
            r.b_prefix = r.a_prefix;
         end
      endcase
      r.a_nil      = ($urandom_range(0, 7) == 0);
      r.b_nil      = ($urandom_range(0, 7) == 0);
      r.new_prefix = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 34));
      return r;
   endfunction

   // offer one request, hold it until taken, then record its expected response
   task automatic issue(input cidr_req_type r, input bit typed, input cidr_rsp_type want,
                        input bit may_idle);
      while (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= r.cmd;
      req_a_addr     <= r.a_addr;
      req_a_prefix   <= r.a_prefix;
      req_a_is_nil   <= r.a_nil;
      req_b_addr     <= r.b_addr;
      req_b_prefix   <= r.b_prefix;
      req_b_is_nil   <= r.b_nil;
      req_new_prefix <= r.new_prefix;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(typed ? want : predict_answer(r));
   endtask

   // ---------------------------------------------------------------- sender

   initial begin
      // comparisons with a nil operand
      add_row(mk_req(CMD_EQ, 32'h0, 6'd0, 1'b1, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b1, '{TRUTH_NIL, 32'd0, 6'd0, 1'b0, 1'b0});
      add_row(mk_req(CMD_LT, 32'h0A00_0001, 6'd8, 1'b0, 32'h0A00_0001, 6'd8, 1'b1, 7'd0),
              1'b1, '{TRUTH_NIL, 32'd0, 6'd0, 1'b0, 1'b0});
      // address extremes and ordering
      add_row(mk_req(CMD_EQ, 32'hFFFF_FFFF, 6'd32, 1'b0, 32'hFFFF_FFFF, 6'd32, 1'b0, 7'd0),
              1'b1, '{TRUTH_TRUE, 32'd0, 6'd0, 1'b0, 1'b0});
      add_row(mk_req(CMD_NEQ, 32'hFFFF_FFFF, 6'd32, 1'b0, 32'hFFFF_FFFF, 6'd31, 1'b0, 7'd0),
              1'b0, '0);
      add_row(mk_req(CMD_LT, 32'h0000_0000, 6'd0, 1'b0, 32'hFFFF_FFFF, 6'd0, 1'b0, 7'd0),
              1'b1, '{TRUTH_TRUE, 32'd0, 6'd0, 1'b0, 1'b0});
      // oversized prefix compared raw
      add_row(mk_req(CMD_GT, 32'hFFFF_FFFF, 6'd63, 1'b0, 32'hFFFF_FFFF, 6'd32, 1'b0, 7'd0),
              1'b1, '{TRUTH_TRUE, 32'd0, 6'd0, 1'b0, 1'b0});
      add_row(mk_req(CMD_LE, 32'h8000_0000, 6'd1, 1'b0, 32'h8000_0000, 6'd1, 1'b0, 7'd0),
              1'b1, '{TRUTH_TRUE, 32'd0, 6'd0, 1'b0, 1'b0});
      // containment
      add_row(mk_req(CMD_CW, 32'h0A01_0200, 6'd24, 1'b0, 32'h0A00_0000, 6'd8, 1'b0, 7'd0),
              1'b0, '0);
      add_row(mk_req(CMD_CWE, 32'h0A00_0000, 6'd8, 1'b0, 32'h0A00_0000, 6'd8, 1'b0, 7'd0),
              1'b0, '0);
      add_row(mk_req(CMD_CS, 32'h0000_0000, 6'd0, 1'b0, 32'hDEAD_BEEF, 6'd32, 1'b0, 7'd0),
              1'b0, '0);
      add_row(mk_req(CMD_CSE, 32'hC0A8_0000, 6'd16, 1'b0, 32'hC0A9_0001, 6'd24, 1'b0, 7'd0),
              1'b0, '0);
      // isnil never answers nil
      add_row(mk_req(CMD_ISNIL, 32'h0, 6'd0, 1'b1, 32'h0, 6'd0, 1'b1, 7'd0),
              1'b1, '{TRUTH_TRUE, 32'd0, 6'd0, 1'b0, 1'b0});
      add_row(mk_req(CMD_ISNIL, 32'h0, 6'd0, 1'b0, 32'h0, 6'd0, 1'b1, 7'd0),
              1'b1, '{TRUTH_FALSE, 32'd0, 6'd0, 1'b0, 1'b0});
      // functions: nil passthrough, mask extremes
      add_row(mk_req(CMD_BCAST, 32'hFFFF_FFFF, 6'd8, 1'b1, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b1, '{TRUTH_FALSE, 32'd0, 6'd0, 1'b1, 1'b0});
      add_row(mk_req(CMD_BCAST, 32'hC0A8_0101, 6'd24, 1'b0, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b0, '0);
      add_row(mk_req(CMD_NETMASK, 32'h1234_5678, 6'd0, 1'b0, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b1, '{TRUTH_FALSE, 32'd0, 6'd32, 1'b0, 1'b0});
      add_row(mk_req(CMD_NETMASK, 32'h1234_5678, 6'd63, 1'b0, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b1, '{TRUTH_FALSE, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0});
      add_row(mk_req(CMD_HOSTMASK, 32'h1234_5678, 6'd32, 1'b0, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b1, '{TRUTH_FALSE, 32'd0, 6'd32, 1'b0, 1'b0});
      add_row(mk_req(CMD_NETWORK, 32'hFFFF_FFFF, 6'd63, 1'b0, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b0, '0);
      add_row(mk_req(CMD_MASKLEN, 32'hFFFF_FFFF, 6'd63, 1'b0, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b1, '{TRUTH_FALSE, 32'd0, 6'd63, 1'b0, 1'b0});
      // setmask: range check before nil, both range ends
      add_row(mk_req(CMD_SETMASK, 32'hFFFF_FFFF, 6'd8, 1'b1, 32'h0, 6'd0, 1'b0, 7'h40),
              1'b1, '{TRUTH_FALSE, 32'd0, 6'd0, 1'b0, 1'b1});
      add_row(mk_req(CMD_SETMASK, 32'hFFFF_FFFF, 6'd8, 1'b0, 32'h0, 6'd0, 1'b0, 7'd33),
              1'b1, '{TRUTH_FALSE, 32'd0, 6'd0, 1'b0, 1'b1});
      add_row(mk_req(CMD_SETMASK, 32'hFFFF_FFFF, 6'd8, 1'b0, 32'h0, 6'd0, 1'b0, 7'd32),
              1'b1, '{TRUTH_FALSE, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0});
      add_row(mk_req(CMD_SETMASK, 32'hFFFF_FFFF, 6'd8, 1'b1, 32'h0, 6'd0, 1'b0, 7'd0),
              1'b1, '{TRUTH_FALSE, 32'd0, 6'd0, 1'b1, 1'b0});
      // unused opcode answers all zeros
      add_row(mk_req(CMD_UNUSED_TOP, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 6'd63,
                     1'b1, 7'h7F),
              1'b1, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i])
         issue(directed_plan[i].stim, directed_plan[i].typed, directed_plan[i].want, 1'b1);

      // random part; a window in the middle runs back to back
      for (int n = 0; n < RAND_REQS; n++)
         issue(rand_req(), 1'b0, '0, !(n >= 900 && n < 1200));
      req_valid <= 1'b0;

      // drain, then wait on past the pipeline depth
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // random stalls, one long hold-off to back up the pipe, one stall-free window
   initial begin
      int unsigned rx_cycle;
      rx_cycle = 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle >= 600 && rx_cycle < 700)
            rsp_stall <= 1'b1;
         else if (rx_cycle >= 1200 && rx_cycle < 1600)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- response check

   always @(posedge clock) begin : check_rsp
      cidr_rsp_type got;
      cidr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_truth, rsp_out_addr, rsp_out_prefix, rsp_out_is_nil, rsp_bad_length};
         if (pending_answers.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: response with no request outstanding: truth %0d addr %h",
                        $realtime, got.truth, got.addr);
         end else begin
            want = pending_answers.pop_front();
            if (got.truth !== want.truth || got.addr !== want.addr ||
                got.prefix !== want.prefix || got.nil !== want.nil ||
                got.bad !== want.bad) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10) begin
                  $display("%0t: mismatch exp truth %0d addr %h pfx %0d nil %b bad %b",
                           $realtime, want.truth, want.addr, want.prefix, want.nil,
                           want.bad);
                  $display("   got truth %0d addr %h pfx %0d nil %b bad %b",
                           got.truth, got.addr, got.prefix, got.nil, got.bad);
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- ipv4_cidr_compare_and_mask_alu_unit.f -----
rtl/core/cicm_pkg.sv
rtl/core/cicm_prep.sv
rtl/core/cicm_relate.sv
rtl/core/cicm_select.sv
rtl/core/ipv4_cidr_compare_and_mask_alu_unit.sv
rtl/core/cicm_checker.sv
tb/tb.sv
